@@ design/assert_macros.svh @@
// assertion macros shared by the aggregator rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition holds on every cycle out of reset
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

`endif

@@ design/wsa_pkg.sv @@
// types and constants of the windowed sample aggregator
package wsa_pkg;

    localparam int unsigned PADDR_W = 3;
    localparam int unsigned PDATA_W = 32;

    localparam int unsigned SECS_NUM_W = 42;
    localparam int unsigned SECS_DEN_W = 10;
    localparam int unsigned MEAN_NUM_W = 24;
    localparam int unsigned PERM_NUM_W = 18;
    localparam int unsigned CNT_W      = 8;

    localparam logic [31:0]            SAMPLE_INTERVAL_RST = 32'd5000;
    localparam logic [31:0]            BUCKET_INTERVAL_RST = 32'd60000;
    localparam logic [SECS_DEN_W-1:0]  MS_PER_SECOND       = 10'd1000;
    localparam logic [9:0]             PERMILLE            = 10'd1000;
    localparam logic [CNT_W-1:0]       COUNT_MAX           = 8'd255;
    localparam logic [63:0]            SAT_MS              = 64'd4294967296000;

    typedef enum logic [1:0] {
        OP_START   = 2'd0,
        OP_OBSERVE = 2'd1,
        OP_FINISH  = 2'd2
    } t_op;

    typedef enum logic {
        REG_SAMPLE_INTERVAL = 1'b0,
        REG_BUCKET_INTERVAL = 1'b1
    } t_reg_idx;

    typedef enum logic {
        BK_IDLE,
        BK_DIV
    } t_back_state;

    typedef struct packed {
        t_op                op;
        logic [31:0]        now_ms;
        logic signed [15:0] actual_centi;
        logic signed [15:0] target_centi;
        logic               heater_on;
        logic [7:0]         mode_code;
        logic [7:0]         step_code;
    } t_item;

    typedef struct packed {
        logic [31:0]        elapsed_seconds;
        logic signed [15:0] min_centi;
        logic signed [15:0] mean_centi;
        logic signed [15:0] max_centi;
        logic signed [15:0] last_target_centi;
        logic [9:0]         heater_permille;
        logic [7:0]         bucket_mode;
        logic [7:0]         bucket_step;
        logic [7:0]         sample_count;
    } t_result;

endpackage

@@ design/wsa_front.sv @@
// front stage: accepts transactions and drops unused op codes
module wsa_front import wsa_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    output logic  o_push_valid,
    output t_item o_push_item,
    input  logic  i_push_ready
);

    logic  r_valid, n_valid;
    t_item r_item, n_item;
    logic  accept;
    logic  is_cmd;

    assign o_ready      = !r_valid || i_push_ready;
    assign accept       = i_valid && o_ready;
    assign is_cmd       = (i_item.op == OP_START) || (i_item.op == OP_OBSERVE) ||
                          (i_item.op == OP_FINISH);
    assign o_push_valid = r_valid;
    assign o_push_item  = r_item;

    always_comb begin
        n_valid = r_valid;
        n_item  = r_item;
        if (r_valid && i_push_ready) begin
            n_valid = 1'b0;
        end
        if (accept) begin
            n_valid = is_cmd;
            n_item  = i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
    end

endmodule

@@ design/wsa_queue.sv @@
// short command queue between front and back
`include "assert_macros.svh"
module wsa_queue import wsa_pkg::*; #(
    parameter int unsigned DEPTH = 2
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push_valid,
    output logic  o_push_ready,
    input  t_item i_push_item,
    output logic  o_pop_valid,
    input  logic  i_pop_ready,
    output t_item o_pop_item
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned QCNT_W = $clog2(DEPTH + 1);

    t_item             r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr, n_wr;
    logic [PTR_W-1:0]  r_rd, n_rd;
    logic [QCNT_W-1:0] r_count, n_count;
    logic              push, pop;

    assign o_push_ready = (r_count != QCNT_W'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_item   = r_mem[r_rd];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        priority if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end else begin
            n_count = r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_push_item;
        end
    end

    `ASSERT_ALWAYS(a_queue_bound, r_count <= QCNT_W'(DEPTH), "queue occupancy above depth")

endmodule

@@ design/wsa_div.sv @@
// bit-serial unsigned restoring divider, one quotient bit per cycle
module wsa_div #(
    parameter int unsigned NUM_W = 24,
    parameter int unsigned DEN_W = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_busy,
    output logic [NUM_W-1:0] o_quot
);

    localparam int unsigned STEP_W = $clog2(NUM_W + 1);

    logic              r_busy, n_busy;
    logic [STEP_W-1:0] r_step, n_step;
    logic [NUM_W-1:0]  r_num, n_num;
    logic [DEN_W-1:0]  r_rem, n_rem;
    logic [DEN_W-1:0]  r_den, n_den;
    logic [DEN_W:0]    shifted;
    logic [DEN_W:0]    diff;
    logic              ge;

    assign shifted = {r_rem, r_num[NUM_W-1]};
    assign ge      = (shifted >= {1'b0, r_den});
    assign diff    = shifted - {1'b0, r_den};
    assign o_busy  = r_busy;
    assign o_quot  = r_num;

    always_comb begin
        n_busy = r_busy;
        n_step = r_step;
        n_num  = r_num;
        n_rem  = r_rem;
        n_den  = r_den;
        if (r_busy) begin
            n_num  = {r_num[NUM_W-2:0], ge};
            n_rem  = ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
            n_step = r_step - 1'b1;
            n_busy = (r_step != STEP_W'(1));
        end else if (i_start) begin
            n_busy = 1'b1;
            n_step = STEP_W'(NUM_W);
            n_num  = i_num;
            n_rem  = '0;
            n_den  = i_den;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_step <= n_step;
        r_num  <= n_num;
        r_rem  <= n_rem;
        r_den  <= n_den;
    end

endmodule

@@ design/wsa_back.sv @@
// back stage: bucket state, closing snapshot, dividers and output register
`include "assert_macros.svh"
module wsa_back import wsa_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_pop_valid,
    output logic        o_pop_ready,
    input  t_item       i_item,
    input  logic [31:0] i_sample_interval,
    input  logic [31:0] i_bucket_interval,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_result     o_result
);

    // seconds by reciprocal multiplication, one 14-bit quotient chunk per cycle
    localparam int unsigned SEC_CHUNK_W = 14;
    localparam int unsigned SEC_D_W     = SECS_DEN_W + SEC_CHUNK_W;
    localparam int unsigned SEC_SHIFT   = SEC_D_W + SECS_DEN_W;
    localparam int unsigned SEC_RECIP_W = 25;
    localparam int unsigned SEC_P_W     = SEC_D_W + SEC_RECIP_W;
    localparam logic [SEC_RECIP_W-1:0] SEC_RECIP = 25'd17179870;
    localparam logic [1:0]  SEC_STEPS   = 2'd3;

    t_back_state r_state, n_state;

    logic               r_recording, n_recording;
    logic [31:0]        r_prev_now, n_prev_now;
    logic [31:0]        r_bucket_start, n_bucket_start;
    logic [31:0]        r_last_accept, n_last_accept;
    logic [63:0]        r_elapsed, n_elapsed;
    logic signed [23:0] r_sum, n_sum;
    logic signed [15:0] r_min, n_min;
    logic signed [15:0] r_max, n_max;
    logic signed [15:0] r_target, n_target;
    logic [7:0]         r_mode, n_mode;
    logic [7:0]         r_step, n_step;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [CNT_W-1:0]   r_heat, n_heat;

    logic [63:0]        r_snap_elapsed;
    logic signed [15:0] r_snap_min, r_snap_max, r_snap_target;
    logic [7:0]         r_snap_mode, r_snap_step;
    logic [CNT_W-1:0]   r_snap_count;
    logic               r_snap_neg;

    logic               r_out_valid, n_out_valid;
    t_result            r_out, n_out;

    logic                  r_sec_busy, n_sec_busy;
    logic [1:0]            r_sec_left, n_sec_left;
    logic [SECS_NUM_W-1:0] r_sec_num, n_sec_num;
    logic [SECS_DEN_W-1:0] r_sec_rem, n_sec_rem;
    logic [SEC_D_W-1:0]    sec_d;
    logic [SEC_P_W-1:0]    sec_prod;
    logic [SEC_CHUNK_W-1:0] sec_q;
    logic [SECS_DEN_W-1:0] sec_qk_lo;

    logic               pop;
    logic [31:0]        d_ms;
    logic [63:0]        elapsed_adv;
    logic               tag_diff, too_soon, bucket_due;
    logic               do_emit, open, add;
    logic [CNT_W-1:0]   base_count, base_heat;
    logic signed [23:0] base_sum;
    logic [MEAN_NUM_W-1:0] sum_mag;
    logic [PERM_NUM_W-1:0] perm_num;
    logic               secs_busy, mean_busy, perm_busy;
    logic [SECS_NUM_W-1:0] secs_q;
    logic [MEAN_NUM_W-1:0] mean_q;
    logic [PERM_NUM_W-1:0] perm_q;
    logic [MEAN_NUM_W-1:0] mean_s;
    logic               div_done, load;

    assign o_pop_ready = (r_state == BK_IDLE);
    assign pop         = i_pop_valid && o_pop_ready;
    assign d_ms        = i_item.now_ms - r_prev_now;
    assign elapsed_adv = r_elapsed + {32'd0, d_ms};
    assign tag_diff    = (i_item.mode_code != r_mode) || (i_item.step_code != r_step);
    assign too_soon    = ((i_item.now_ms - r_last_accept) < i_sample_interval);
    assign bucket_due  = ((i_item.now_ms - r_bucket_start) >= i_bucket_interval);
    assign sum_mag     = r_sum[23] ? MEAN_NUM_W'(-r_sum) : MEAN_NUM_W'(r_sum);
    assign perm_num    = PERM_NUM_W'(r_heat) * PERM_NUM_W'(PERMILLE);

    always_comb begin
        n_recording    = r_recording;
        n_prev_now     = r_prev_now;
        n_bucket_start = r_bucket_start;
        n_last_accept  = r_last_accept;
        n_elapsed      = r_elapsed;
        n_sum          = r_sum;
        n_min          = r_min;
        n_max          = r_max;
        n_target       = r_target;
        n_mode         = r_mode;
        n_step         = r_step;
        n_count        = r_count;
        n_heat         = r_heat;
        do_emit        = 1'b0;
        open           = 1'b0;
        add            = 1'b0;

        if (pop) begin
            unique case (i_item.op)
                OP_START: begin
                    n_recording = 1'b1;
                    n_prev_now  = i_item.now_ms;
                    n_elapsed   = '0;
                    open        = 1'b1;
                end
                OP_OBSERVE: begin
                    if (r_recording) begin
                        n_elapsed  = elapsed_adv;
                        n_prev_now = i_item.now_ms;
                        priority if (tag_diff) begin
                            do_emit = 1'b1;
                            open    = 1'b1;
                        end else if (too_soon) begin
                            do_emit = 1'b0;
                        end else if (bucket_due) begin
                            do_emit = 1'b1;
                            open    = 1'b1;
                        end else begin
                            n_last_accept = i_item.now_ms;
                            add           = 1'b1;
                        end
                    end
                end
                OP_FINISH: begin
                    if (r_recording) begin
                        n_elapsed   = elapsed_adv;
                        n_prev_now  = i_item.now_ms;
                        n_recording = 1'b0;
                        do_emit     = (r_count != '0);
                    end
                end
                default: begin
                    do_emit = 1'b0;
                end
            endcase
        end

        base_count = open ? '0 : r_count;
        base_heat  = open ? '0 : r_heat;
        base_sum   = open ? '0 : r_sum;
        if (open) begin
            n_bucket_start = i_item.now_ms;
            n_last_accept  = i_item.now_ms;
            n_count        = '0;
            n_heat         = '0;
            n_sum          = '0;
        end
        if (open || add) begin
            priority if (base_count == '0) begin
                n_min  = i_item.actual_centi;
                n_max  = i_item.actual_centi;
                n_mode = i_item.mode_code;
                n_step = i_item.step_code;
            end else if (base_count >= COUNT_MAX) begin
                n_min = r_min;
            end else begin
                if (i_item.actual_centi < r_min) n_min = i_item.actual_centi;
                if (i_item.actual_centi > r_max) n_max = i_item.actual_centi;
            end
            if (base_count < COUNT_MAX) begin
                n_sum    = base_sum + 24'(i_item.actual_centi);
                n_target = i_item.target_centi;
                n_count  = base_count + 1'b1;
                n_heat   = base_heat + CNT_W'(i_item.heater_on);
            end
        end
    end

    // remainder below 1000 keeps each chunk dividend under 2^24
    assign sec_d     = {r_sec_rem, r_sec_num[SECS_NUM_W-1 -: SEC_CHUNK_W]};
    assign sec_prod  = SEC_P_W'(sec_d) * SEC_P_W'(SEC_RECIP);
    assign sec_q     = sec_prod[SEC_SHIFT +: SEC_CHUNK_W];
    assign sec_qk_lo = SECS_DEN_W'(sec_q) * MS_PER_SECOND;
    assign secs_busy = r_sec_busy;
    assign secs_q    = r_sec_num;

    always_comb begin
        n_sec_busy = r_sec_busy;
        n_sec_left = r_sec_left;
        n_sec_num  = r_sec_num;
        n_sec_rem  = r_sec_rem;
        if (r_sec_busy) begin
            n_sec_num  = {r_sec_num[SECS_NUM_W-SEC_CHUNK_W-1:0], sec_q};
            n_sec_rem  = sec_d[SECS_DEN_W-1:0] - sec_qk_lo;
            n_sec_left = r_sec_left - 1'b1;
            n_sec_busy = (r_sec_left != 2'd1);
        end else if (do_emit) begin
            n_sec_busy = 1'b1;
            n_sec_left = SEC_STEPS;
            n_sec_num  = elapsed_adv[SECS_NUM_W-1:0];
            n_sec_rem  = '0;
        end
    end

    wsa_div #(.NUM_W(MEAN_NUM_W), .DEN_W(CNT_W)) u_div_mean (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (do_emit),
        .i_num   (sum_mag),
        .i_den   (r_count),
        .o_busy  (mean_busy),
        .o_quot  (mean_q)
    );

    wsa_div #(.NUM_W(PERM_NUM_W), .DEN_W(CNT_W)) u_div_perm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (do_emit),
        .i_num   (perm_num),
        .i_den   (r_count),
        .o_busy  (perm_busy),
        .o_quot  (perm_q)
    );

    assign div_done = !secs_busy && !mean_busy && !perm_busy;
    assign load     = (r_state == BK_DIV) && div_done && (!r_out_valid || i_out_ready);
    assign mean_s   = r_snap_neg ? (~mean_q + 1'b1) : mean_q;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        unique case (r_state)
            BK_IDLE: begin
                if (do_emit) n_state = BK_DIV;
            end
            BK_DIV: begin
                if (load) n_state = BK_IDLE;
            end
        endcase
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (load) begin
            n_out_valid                 = 1'b1;
            n_out.elapsed_seconds       = (r_snap_elapsed >= SAT_MS) ? '1 : secs_q[31:0];
            n_out.min_centi             = r_snap_min;
            n_out.mean_centi            = mean_s[15:0];
            n_out.max_centi             = r_snap_max;
            n_out.last_target_centi     = r_snap_target;
            n_out.heater_permille       = perm_q[9:0];
            n_out.bucket_mode           = r_snap_mode;
            n_out.bucket_step           = r_snap_step;
            n_out.sample_count          = r_snap_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= BK_IDLE;
            r_out_valid    <= 1'b0;
            r_sec_busy     <= 1'b0;
            r_recording    <= 1'b0;
            r_prev_now     <= '0;
            r_bucket_start <= '0;
            r_last_accept  <= '0;
            r_elapsed      <= '0;
            r_sum          <= '0;
            r_min          <= '0;
            r_max          <= '0;
            r_target       <= '0;
            r_mode         <= '0;
            r_step         <= '0;
            r_count        <= '0;
            r_heat         <= '0;
        end else begin
            r_state        <= n_state;
            r_out_valid    <= n_out_valid;
            r_sec_busy     <= n_sec_busy;
            r_recording    <= n_recording;
            r_prev_now     <= n_prev_now;
            r_bucket_start <= n_bucket_start;
            r_last_accept  <= n_last_accept;
            r_elapsed      <= n_elapsed;
            r_sum          <= n_sum;
            r_min          <= n_min;
            r_max          <= n_max;
            r_target       <= n_target;
            r_mode         <= n_mode;
            r_step         <= n_step;
            r_count        <= n_count;
            r_heat         <= n_heat;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out      <= n_out;
        r_sec_left <= n_sec_left;
        r_sec_num  <= n_sec_num;
        r_sec_rem  <= n_sec_rem;
        if (do_emit) begin
            r_snap_elapsed <= elapsed_adv;
            r_snap_min     <= r_min;
            r_snap_max     <= r_max;
            r_snap_target  <= r_target;
            r_snap_mode    <= r_mode;
            r_snap_step    <= r_step;
            r_snap_count   <= r_count;
            r_snap_neg     <= r_sum[23];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

    `ASSERT_IMPLIES(a_rec_count, r_recording, r_count != '0, "recording with empty bucket")
    `ASSERT_IMPLIES(a_out_sane, r_out_valid,
        (r_out.sample_count != '0) && (r_out.heater_permille <= PERMILLE),
        "emitted aggregate out of range")
    `ASSERT_IMPLIES(a_div_state, secs_busy, r_state == BK_DIV, "divider running outside div state")

endmodule

@@ design/windowed_sample_aggregator.sv @@
// top level of the windowed sample aggregator with apb register port
//
// channel   direction  handshake                  payload
// input     in         i_in_valid / o_in_ready    i_op .. i_step_code
// result    out        o_out_valid / i_out_ready  o_elapsed_seconds .. o_sample_count
// config    in         psel penable pwrite pready paddr pwdata / prdata
//
// a transaction passes the front register and the queue before it updates the bucket state
// a closing transaction holds the back until its dividers are done, the longest being the
// 24-step mean divider, and its result is then loaded into the result register
// the front and the queue keep taking transactions while the back divides
// a full result register stalls the back, and the queue then fills and drops o_in_ready
// reset is synchronous and needs no clearing pass
module windowed_sample_aggregator import wsa_pkg::*; #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic               i_clk,
    input  logic               i_rst_n,

    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_op,
    input  logic [31:0]        i_now_ms,
    input  logic signed [15:0] i_actual_centi,
    input  logic signed [15:0] i_target_centi,
    input  logic               i_heater_on,
    input  logic [7:0]         i_mode_code,
    input  logic [7:0]         i_step_code,

    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [31:0]        o_elapsed_seconds,
    output logic signed [15:0] o_min_centi,
    output logic signed [15:0] o_mean_centi,
    output logic signed [15:0] o_max_centi,
    output logic signed [15:0] o_last_target_centi,
    output logic [9:0]         o_heater_permille,
    output logic [7:0]         o_bucket_mode,
    output logic [7:0]         o_bucket_step,
    output logic [7:0]         o_sample_count,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    logic [31:0] r_sample_interval;
    logic [31:0] r_bucket_interval;
    logic        cfg_wr;
    t_reg_idx    reg_idx;

    t_item   in_item;
    logic    push_valid, push_ready;
    t_item   push_item;
    logic    pop_valid, pop_ready;
    t_item   pop_item;
    t_result result;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = t_reg_idx'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_interval <= SAMPLE_INTERVAL_RST;
            r_bucket_interval <= BUCKET_INTERVAL_RST;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_SAMPLE_INTERVAL: r_sample_interval <= pwdata;
                REG_BUCKET_INTERVAL: r_bucket_interval <= pwdata;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_SAMPLE_INTERVAL: prdata = r_sample_interval;
            REG_BUCKET_INTERVAL: prdata = r_bucket_interval;
        endcase
    end

    assign in_item = '{
        op:           t_op'(i_op),
        now_ms:       i_now_ms,
        actual_centi: i_actual_centi,
        target_centi: i_target_centi,
        heater_on:    i_heater_on,
        mode_code:    i_mode_code,
        step_code:    i_step_code
    };

    wsa_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in_valid),
        .o_ready      (o_in_ready),
        .i_item       (in_item),
        .o_push_valid (push_valid),
        .o_push_item  (push_item),
        .i_push_ready (push_ready)
    );

    wsa_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_item  (push_item),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_item   (pop_item)
    );

    wsa_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_pop_valid       (pop_valid),
        .o_pop_ready       (pop_ready),
        .i_item            (pop_item),
        .i_sample_interval (r_sample_interval),
        .i_bucket_interval (r_bucket_interval),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_result          (result)
    );

    assign o_elapsed_seconds   = result.elapsed_seconds;
    assign o_min_centi         = result.min_centi;
    assign o_mean_centi        = result.mean_centi;
    assign o_max_centi         = result.max_centi;
    assign o_last_target_centi = result.last_target_centi;
    assign o_heater_permille   = result.heater_permille;
    assign o_bucket_mode       = result.bucket_mode;
    assign o_bucket_step       = result.bucket_step;
    assign o_sample_count      = result.sample_count;

endmodule

@@ tb/wsa_checker.sv @@
// checker that predicts the aggregator's bucket summaries and compares every result transaction
module wsa_checker
    import wsa_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,

    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic [1:0]         i_op,
    input  logic [31:0]        i_now_ms,
    input  logic signed [15:0] i_actual_centi,
    input  logic signed [15:0] i_target_centi,
    input  logic               i_heater_on,
    input  logic [7:0]         i_mode_code,
    input  logic [7:0]         i_step_code,

    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic [31:0]        i_elapsed_seconds,
    input  logic signed [15:0] i_min_centi,
    input  logic signed [15:0] i_mean_centi,
    input  logic signed [15:0] i_max_centi,
    input  logic signed [15:0] i_last_target_centi,
    input  logic [9:0]         i_heater_permille,
    input  logic [7:0]         i_bucket_mode,
    input  logic [7:0]         i_bucket_step,
    input  logic [7:0]         i_sample_count,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    input  logic               pready,

    output int                 o_mismatches,
    output int                 o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [31:0]        sample_gap_ms;
    logic [31:0]        bucket_len_ms;

    bit                 rec_active;
    logic [31:0]        last_now_ms;
    logic [31:0]        bucket_open_ms;
    logic [31:0]        last_taken_ms;
    logic [63:0]        elapsed_ms;
    int                 sum_centi;
    logic signed [15:0] lo_centi;
    logic signed [15:0] hi_centi;
    logic signed [15:0] tgt_centi;
    logic [7:0]         tag_mode;
    logic [7:0]         tag_step;
    logic [7:0]         n_samples;
    logic [7:0]         n_heated;

    t_result            pending_summaries[$];
    t_result            oldest_summary;
    int                 mismatch_count = 0;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at %0t ns: %s got %h expected %h", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            report_mismatch(what, got, want);
        end
    endtask

    task automatic add_sample(input logic signed [15:0] actual, input logic signed [15:0] target,
                              input logic heat, input logic [7:0] mode, input logic [7:0] step);
        if (n_samples == 8'd0) begin
            lo_centi = actual;
            hi_centi = actual;
            tag_mode = mode;
            tag_step = step;
        end else if (n_samples >= COUNT_MAX) begin
            return;
        end else begin
            if (actual < lo_centi) lo_centi = actual;
            if (actual > hi_centi) hi_centi = actual;
        end
        sum_centi += actual;
        tgt_centi = target;
        n_samples = n_samples + 8'd1;
        if (heat) n_heated = n_heated + 8'd1;
    endtask

    task automatic open_bucket(input logic [31:0] now, input logic signed [15:0] actual,
                               input logic signed [15:0] target, input logic heat,
                               input logic [7:0] mode, input logic [7:0] step);
        bucket_open_ms = now;
        last_taken_ms = now;
        sum_centi = 0;
        n_samples = 8'd0;
        n_heated = 8'd0;
        add_sample(actual, target, heat, mode, step);
    endtask

    function automatic t_result summarize_bucket();
        t_result     r;
        logic [63:0] secs;
        secs = elapsed_ms / MS_PER_SECOND;
        r.elapsed_seconds = (secs > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : secs[31:0];
        r.min_centi = lo_centi;
        r.max_centi = hi_centi;
        r.last_target_centi = tgt_centi;
        r.mean_centi = '0;
        r.heater_permille = '0;
        if (n_samples != 8'd0) begin
            r.mean_centi = 16'(sum_centi / int'(n_samples));
            r.heater_permille = 10'((int'(n_heated) * int'(PERMILLE)) / int'(n_samples));
        end
        r.bucket_mode = tag_mode;
        r.bucket_step = tag_step;
        r.sample_count = n_samples;
        return r;
    endfunction

    task automatic advance_clock(input logic [31:0] now);
        logic [31:0] delta;
        delta = now - last_now_ms;
        elapsed_ms = elapsed_ms + {32'd0, delta};
        last_now_ms = now;
    endtask

    task automatic apply_item();
        logic [31:0] now;
        logic [31:0] since_taken;
        logic [31:0] since_open;
        now = i_now_ms;
        case (i_op)
            OP_START: begin
                rec_active = 1'b1;
                elapsed_ms = '0;
                last_now_ms = now;
                lo_centi = '0;
                hi_centi = '0;
                tgt_centi = '0;
                tag_mode = '0;
                tag_step = '0;
                open_bucket(now, i_actual_centi, i_target_centi, i_heater_on,
                            i_mode_code, i_step_code);
            end
            OP_OBSERVE: begin
                if (rec_active) begin
                    advance_clock(now);
                    since_taken = now - last_taken_ms;
                    since_open = now - bucket_open_ms;
                    if (i_mode_code != tag_mode || i_step_code != tag_step) begin
                        pending_summaries.push_back(summarize_bucket());
                        open_bucket(now, i_actual_centi, i_target_centi, i_heater_on,
                                    i_mode_code, i_step_code);
                    end else if (since_taken < sample_gap_ms) begin
                        // too soon, dropped
                    end else if (since_open >= bucket_len_ms) begin
                        pending_summaries.push_back(summarize_bucket());
                        open_bucket(now, i_actual_centi, i_target_centi, i_heater_on,
                                    i_mode_code, i_step_code);
                    end else begin
                        last_taken_ms = now;
                        add_sample(i_actual_centi, i_target_centi, i_heater_on,
                                   i_mode_code, i_step_code);
                    end
                end
            end
            OP_FINISH: begin
                if (rec_active) begin
                    advance_clock(now);
                    rec_active = 1'b0;
                    if (n_samples != 8'd0) pending_summaries.push_back(summarize_bucket());
                end
            end
            default: ;
        endcase
    endtask

    task automatic compare_summary(input t_result want);
        check_field("elapsed_seconds", i_elapsed_seconds, want.elapsed_seconds);
        check_field("min_centi", i_min_centi, want.min_centi);
        check_field("mean_centi", i_mean_centi, want.mean_centi);
        check_field("max_centi", i_max_centi, want.max_centi);
        check_field("last_target_centi", i_last_target_centi, want.last_target_centi);
        check_field("heater_permille", i_heater_permille, want.heater_permille);
        check_field("bucket_mode", i_bucket_mode, want.bucket_mode);
        check_field("bucket_step", i_bucket_step, want.bucket_step);
        check_field("sample_count", i_sample_count, want.sample_count);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            sample_gap_ms = SAMPLE_INTERVAL_RST;
            bucket_len_ms = BUCKET_INTERVAL_RST;
            rec_active = 1'b0;
            last_now_ms = '0;
            bucket_open_ms = '0;
            last_taken_ms = '0;
            elapsed_ms = '0;
            sum_centi = 0;
            lo_centi = '0;
            hi_centi = '0;
            tgt_centi = '0;
            tag_mode = '0;
            tag_step = '0;
            n_samples = '0;
            n_heated = '0;
            pending_summaries.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr >> 2)
                    REG_SAMPLE_INTERVAL: sample_gap_ms = pwdata[31:0];
                    REG_BUCKET_INTERVAL: bucket_len_ms = pwdata[31:0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (pending_summaries.size() == 0) begin
                    report_mismatch("result with nothing expected, sample_count",
                                    i_sample_count, 32'd0);
                end else begin
                    oldest_summary = pending_summaries.pop_front();
                    compare_summary(oldest_summary);
                end
            end
            if (i_in_valid && i_in_ready) begin
                apply_item();
            end
        end
        o_mismatches <= mismatch_count;
        o_outstanding <= pending_summaries.size();
    end

endmodule

@@ tb/tb.sv @@
// stimulus, register setup and verdict for the windowed sample aggregator
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import wsa_pkg::*;

    localparam int unsigned LIMIT_CYCLES  = 400000;
    localparam int unsigned MAX_IDLE      = 13;
    localparam int unsigned SETTLE_CYCLES = 60;
    localparam int unsigned END_CYCLES    = 100;
    localparam logic [1:0]  OP_UNUSED     = 2'd3;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;

    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic [1:0]         i_op = '0;
    logic [31:0]        i_now_ms = '0;
    logic signed [15:0] i_actual_centi = '0;
    logic signed [15:0] i_target_centi = '0;
    logic               i_heater_on = 1'b0;
    logic [7:0]         i_mode_code = '0;
    logic [7:0]         i_step_code = '0;

    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic [31:0]        o_elapsed_seconds;
    logic signed [15:0] o_min_centi;
    logic signed [15:0] o_mean_centi;
    logic signed [15:0] o_max_centi;
    logic signed [15:0] o_last_target_centi;
    logic [9:0]         o_heater_permille;
    logic [7:0]         o_bucket_mode;
    logic [7:0]         o_bucket_step;
    logic [7:0]         o_sample_count;

    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    int                 mismatches;
    int                 outstanding;
    int unsigned        cycle_count = 0;

    logic [31:0]        cfg_sample = SAMPLE_INTERVAL_RST;
    logic [31:0]        cfg_bucket = BUCKET_INTERVAL_RST;
    logic [31:0]        clock_ms = '0;
    logic [7:0]         cur_mode = '0;
    logic [7:0]         cur_step = '0;
    bit                 session_open = 1'b0;
    bit                 in_burst = 1'b0;
    bit                 out_burst = 1'b0;

    windowed_sample_aggregator DUT (.*);

    wsa_checker summary_check (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .i_in_ready          (o_in_ready),
        .i_op                (i_op),
        .i_now_ms            (i_now_ms),
        .i_actual_centi      (i_actual_centi),
        .i_target_centi      (i_target_centi),
        .i_heater_on         (i_heater_on),
        .i_mode_code         (i_mode_code),
        .i_step_code         (i_step_code),
        .i_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .i_elapsed_seconds   (o_elapsed_seconds),
        .i_min_centi         (o_min_centi),
        .i_mean_centi        (o_mean_centi),
        .i_max_centi         (o_max_centi),
        .i_last_target_centi (o_last_target_centi),
        .i_heater_permille   (o_heater_permille),
        .i_bucket_mode       (o_bucket_mode),
        .i_bucket_step       (o_bucket_step),
        .i_sample_count      (o_sample_count),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .pready              (pready),
        .o_mismatches        (mismatches),
        .o_outstanding       (outstanding)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("FAIL windowed_sample_aggregator");
            $finish;
        end
    end

    task automatic write_reg(input t_reg_idx idx, input logic [31:0] value);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= PADDR_W'({idx, 2'b00});
        pwdata <= PDATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_SAMPLE_INTERVAL) cfg_sample = value;
        else cfg_bucket = value;
    endtask

    task automatic send_item(input logic [1:0] op, input logic [31:0] now,
                             input logic signed [15:0] actual, input logic signed [15:0] target,
                             input logic heat, input logic [7:0] mode, input logic [7:0] step);
        int idle;
        idle = in_burst ? 0 : $urandom_range(0, MAX_IDLE);
        if ($urandom_range(0, 39) == 0) in_burst = !in_burst;
        if (idle > 0) begin
            i_in_valid <= 1'b0;
            repeat (idle) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op <= op;
        i_now_ms <= now;
        i_actual_centi <= actual;
        i_target_centi <= target;
        i_heater_on <= heat;
        i_mode_code <= mode;
        i_step_code <= step;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apply_intervals(input logic [31:0] sample_ms, input logic [31:0] bucket_ms);
        drain();
        write_reg(REG_SAMPLE_INTERVAL, sample_ms);
        write_reg(REG_BUCKET_INTERVAL, bucket_ms);
    endtask

    function automatic logic signed [15:0] pick_temp();
        case ($urandom_range(0, 7))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return 16'(int'($urandom_range(0, 100)) - 50);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] pick_tag();
        if ($urandom_range(0, 3) == 0) return 8'($urandom);
        return 8'($urandom_range(0, 2));
    endfunction

    function automatic logic [31:0] pick_step_ms();
        case ($urandom_range(0, 9))
            0: return 32'($urandom_range(0, 3));
            1: return cfg_sample;
            2: return cfg_sample - 32'd1;
            3: return $urandom;
            default: return cfg_sample + $urandom_range(0, cfg_bucket / 8 + 16);
        endcase
    endfunction

    task automatic run_phase(input int n_items, input int tag_pct, input int noise_pct,
                             input int min_len, input int max_len);
        int         left;
        logic [1:0] op;
        left = 0;
        for (int k = 0; k < n_items; k++) begin
            if ($urandom_range(1, 100) <= noise_pct) op = 2'($urandom_range(0, 3));
            else if (!session_open) op = OP_START;
            else if (left == 0) op = OP_FINISH;
            else op = OP_OBSERVE;
            if (op == OP_START) begin
                left = $urandom_range(min_len, max_len);
                session_open = 1'b1;
            end else if (op == OP_FINISH) begin
                session_open = 1'b0;
            end else if (op == OP_OBSERVE && left > 0) begin
                left--;
            end
            if ($urandom_range(1, 100) <= tag_pct) begin
                case ($urandom_range(0, 2))
                    0: cur_mode = pick_tag();
                    1: cur_step = pick_tag();
                    default: begin
                        cur_mode = pick_tag();
                        cur_step = pick_tag();
                    end
                endcase
            end
            if (op == OP_START && $urandom_range(0, 3) == 0) clock_ms = $urandom;
            else clock_ms = clock_ms + pick_step_ms();
            send_item(op, clock_ms, pick_temp(), 16'($urandom), 1'($urandom),
                      cur_mode, cur_step);
        end
    endtask

    initial begin
        int stall;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = out_burst ? 0 : $urandom_range(0, MAX_IDLE);
            if ($urandom_range(0, 29) == 0) out_burst = !out_burst;
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_out_valid && i_out_ready));
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_reg(REG_SAMPLE_INTERVAL, SAMPLE_INTERVAL_RST);
        write_reg(REG_BUCKET_INTERVAL, BUCKET_INTERVAL_RST);

        // ignored while idle, and the unused code
        send_item(OP_OBSERVE, 32'd100, 16'sd0, 16'sd0, 1'b0, 8'd0, 8'd0);
        send_item(OP_FINISH, 32'd200, 16'sd0, 16'sd0, 1'b0, 8'd0, 8'd0);
        send_item(OP_UNUSED, 32'd300, 16'sd0, 16'sd0, 1'b0, 8'd0, 8'd0);
        // one session: too soon, boundary gap, then tag changes and interval close
        send_item(OP_START, 32'd1000, 16'sh8000, 16'sh7FFF, 1'b1, 8'd0, 8'd0);
        send_item(OP_OBSERVE, 32'd2000, 16'sd100, 16'sd5, 1'b1, 8'd0, 8'd0);
        send_item(OP_OBSERVE, 32'd6000, 16'sh7FFF, 16'sh8000, 1'b0, 8'd0, 8'd0);
        send_item(OP_OBSERVE, 32'd11000, -16'sd3, 16'sd7, 1'b1, 8'd0, 8'd0);
        send_item(OP_OBSERVE, 32'd12000, 16'sd20, 16'sd20, 1'b0, 8'hFF, 8'd0);
        send_item(OP_OBSERVE, 32'd13000, 16'sd21, 16'sd21, 1'b1, 8'hFF, 8'hFF);
        send_item(OP_OBSERVE, 32'd18000, 16'sd22, 16'sd0, 1'b0, 8'hFF, 8'hFF);
        send_item(OP_OBSERVE, 32'd73000, 16'sd23, 16'sd0, 1'b1, 8'hFF, 8'hFF);
        send_item(OP_UNUSED, 32'd74000, 16'sd0, 16'sd0, 1'b0, 8'd0, 8'd0);
        // restart while recording, timestamp wrap, negative mean truncation
        send_item(OP_START, 32'hFFFF_F000, -16'sd3, 16'sd0, 1'b0, 8'd7, 8'd9);
        send_item(OP_OBSERVE, 32'h0000_0388, -16'sd2, 16'sd1, 1'b1, 8'd7, 8'd9);
        send_item(OP_FINISH, 32'h0000_1000, 16'sd0, 16'sd0, 1'b0, 8'd7, 8'd9);
        // single-sample bucket and a full-range elapsed time
        send_item(OP_START, 32'd0, 16'sd1, -16'sd1, 1'b0, 8'hAA, 8'h55);
        send_item(OP_FINISH, 32'hFFFF_FFFF, 16'sd0, 16'sd0, 1'b1, 8'hAA, 8'h55);
        // sample just behind the last one wraps to a huge gap
        send_item(OP_START, 32'd5, 16'sh7FFF, 16'sd0, 1'b1, 8'h55, 8'hAA);
        send_item(OP_OBSERVE, 32'd4, 16'sd0, 16'sd0, 1'b0, 8'h55, 8'hAA);
        send_item(OP_FINISH, 32'd10000, 16'sd0, 16'sd0, 1'b0, 8'h55, 8'hAA);

        clock_ms = 32'd10000;
        session_open = 1'b0;
        run_phase(80, 15, 8, 1, 40);

        apply_intervals(32'd0, 32'd0);
        run_phase(50, 20, 10, 1, 15);

        // long run with fixed tags fills a bucket past its count limit
        apply_intervals(32'd0, 32'hFFFF_FFFF);
        run_phase(280, 0, 0, 270, 276);

        apply_intervals(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        run_phase(40, 30, 10, 1, 10);

        repeat (2) begin
            apply_intervals($urandom_range(0, 3000), $urandom_range(0, 20000));
            run_phase(50, 15, 8, 1, 30);
        end

        drain();
        repeat (END_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("PASS windowed_sample_aggregator");
        end else begin
            $display("FAIL windowed_sample_aggregator");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+design
design/wsa_pkg.sv
design/wsa_front.sv
design/wsa_queue.sv
design/wsa_div.sv
design/wsa_back.sv
design/windowed_sample_aggregator.sv
tb/wsa_checker.sv
tb/tb.sv
